>>> src/rwcs_pkg.sv
// Shared types, constants and the quarter-wave cosine table for the wall column shader.
package rwcs_pkg;

  localparam int COS_ENTRIES   = 1024;
  localparam int COS_IDX_BITS  = 10;
  localparam int ANGLE_BITS    = 16;
  localparam int COS_QTR       = COS_ENTRIES / 4;
  localparam int COS_HALF      = COS_ENTRIES / 2;
  localparam int TILE_BITS     = 6;
  localparam int SCALE_BITS    = 24;
  localparam int FIX_BITS      = 16;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = 3;
  localparam int FIFO_CNT_BITS = 4;
  localparam int FRONT_STAGES  = 3;

  localparam longint unsigned PI_Q28  = 64'd843314857;
  localparam longint unsigned ONE_Q28 = 64'd268435456;

  localparam logic [1:0] REGION_CEILING = 2'd0;
  localparam logic [1:0] REGION_WALL    = 2'd1;
  localparam logic [1:0] REGION_FLOOR   = 2'd2;

  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  localparam logic [1:0] REG_HEIGHT_SCALE  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CEILING_COLOR = 2'd2;
  localparam logic [1:0] REG_FLOOR_COLOR   = 2'd3;

  typedef logic [16:0] cos_qtab_t [0:COS_QTR];

  typedef struct packed {
    logic [11:0]          column;
    logic [11:0]          row;
    logic [FIX_BITS-1:0]  fix;
    logic [1:0]           face;
    logic [TILE_BITS-1:0] tex_u;
  } req_t;

  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [16:0] cos_first(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint unsigned r;
    longint          sum;
    x2   = (x * x) >> 28;
    term = ONE_Q28;
    sum  = longint'(ONE_Q28);
    for (int n = 1; n <= 10; n++) begin
      den  = longint'((2 * n - 1) * (2 * n));
      term = udiv64((term * x2) >> 28, den);
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) + 2048) >> 12;
    if (r > 65536) r = 65536;
    return r[16:0];
  endfunction

  function automatic cos_qtab_t build_cos_qtab();
    cos_qtab_t t;
    for (int q = 0; q <= COS_QTR; q++) begin
      t[q] = cos_first((2 * PI_Q28 * longint'(q)) >> COS_IDX_BITS);
    end
    return t;
  endfunction

  localparam cos_qtab_t COS_QTAB = build_cos_qtab();

endpackage

>>> src/raycast_wall_column_shader_top.sv
// Top level of the raycast wall column shader.
// Throughput: one request per cycle while busy is low; results leave in request order.
// The back end holds the 24-step height divider and the 6-step texel row divider.
// busy rises only if the request queue nears full; the receiver cannot stall.
// Synchronous reset clears all valid state and loads the register reset values.
module raycast_wall_column_shader_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [11:0] column,
  input  logic [11:0] row,
  input  logic [23:0] ray_distance,
  input  logic [15:0] ray_dir,
  input  logic [15:0] view_angle,
  input  logic        hit_vertical,
  input  logic [15:0] hit_x,
  input  logic [15:0] hit_y,
  output logic        done,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic [1:0]  region,
  output logic [1:0]  face,
  output logic [5:0]  tex_u,
  output logic [5:0]  tex_v,
  output logic [31:0] pixel_color
);
  import rwcs_pkg::*;

  logic [23:0] height_scale;
  logic [11:0] screen_height;
  logic [31:0] ceiling_color;
  logic [31:0] floor_color;

  logic                     accept;
  logic                     push;
  req_t                     push_data;
  req_t                     head;
  logic [FIFO_CNT_BITS-1:0] count;
  logic                     pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_scale  <= 24'd1200000;
      screen_height <= 12'd720;
      ceiling_color <= '0;
      floor_color   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT_SCALE:  height_scale  <= cfg_data[23:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        REG_CEILING_COLOR: ceiling_color <= cfg_data;
        REG_FLOOR_COLOR:   floor_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy   = (count >= FIFO_CNT_BITS'(FIFO_DEPTH - FRONT_STAGES));
  assign accept = start && !busy;
  assign pop    = (count != '0);

  rwcs_front u_front (
    .clk, .rst, .accept,
    .column, .row, .ray_distance, .ray_dir, .view_angle,
    .hit_vertical, .hit_x, .hit_y,
    .push, .push_data
  );

  rwcs_fifo u_fifo (
    .clk, .rst, .push, .push_data, .pop, .head, .count
  );

  rwcs_back u_back (
    .clk, .rst,
    .in_valid (pop),
    .in_req   (head),
    .height_scale, .screen_height, .ceiling_color, .floor_color,
    .done, .out_column, .out_row, .region, .face, .tex_u, .tex_v, .pixel_color
  );

`ifndef SYNTHESIS
  a_wall_no_color: assert property (@(posedge clk) disable iff (rst)
    (done && region == REGION_WALL) |-> pixel_color == '0)
    else $error("wall pixel carries a color");
  a_flat_no_tex: assert property (@(posedge clk) disable iff (rst)
    (done && region != REGION_WALL) |-> (face == '0 && tex_u == '0 && tex_v == '0))
    else $error("ceiling or floor pixel carries texel data");
  a_region_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (region == REGION_CEILING || region == REGION_WALL || region == REGION_FLOOR))
    else $error("unused region code");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("request queue overflow");
`endif

endmodule

>>> src/rwcs_front.sv
// Front end: request capture, face and texel column selection, cosine lookup, distance correction.
module rwcs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [11:0]          column,
  input  logic [11:0]          row,
  input  logic [23:0]          ray_distance,
  input  logic [15:0]          ray_dir,
  input  logic [15:0]          view_angle,
  input  logic                 hit_vertical,
  input  logic [15:0]          hit_x,
  input  logic [15:0]          hit_y,
  output logic                 push,
  output rwcs_pkg::req_t       push_data
);
  import rwcs_pkg::*;

  logic        s1_valid, s2_valid, s3_valid;
  logic [11:0] s1_column, s1_row;
  logic [23:0] s1_dist;
  logic [15:0] s1_diff;
  logic [1:0]  s1_face;
  logic [TILE_BITS-1:0] s1_tu;
  req_t        s2_meta, s3_meta;
  logic [23:0] s2_dist;
  logic [16:0] s2_cos;
  logic [40:0] s3_prod;

  logic [COS_IDX_BITS-1:0] idx;
  logic [COS_IDX_BITS:0]   fold;
  logic [16:0]             cos_val;
  logic [FIX_BITS-1:0]     fix_raw;
  logic [1:0]              face_c;

  always_comb begin
    idx  = s1_diff[ANGLE_BITS-1 -: COS_IDX_BITS];
    fold = (idx > COS_IDX_BITS'(COS_HALF)) ? ((COS_IDX_BITS+1)'(COS_ENTRIES) - {1'b0, idx})
                                           : {1'b0, idx};
    cos_val = (fold <= (COS_IDX_BITS+1)'(COS_QTR)) ? COS_QTAB[fold[COS_IDX_BITS-2:0]] : 17'd0;
  end

  always_comb begin
    if (hit_vertical) begin
      face_c = (ray_dir[15:14] == 2'd0 || ray_dir[15:14] == 2'd3) ? FACE_EAST : FACE_WEST;
    end else begin
      face_c = ray_dir[15] ? FACE_SOUTH : FACE_NORTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_column <= column;
    s1_row    <= row;
    s1_dist   <= ray_distance;
    s1_diff   <= ray_dir - view_angle;
    s1_face   <= face_c;
    s1_tu     <= hit_vertical ? hit_y[TILE_BITS-1:0] : hit_x[TILE_BITS-1:0];

    s2_meta.column <= s1_column;
    s2_meta.row    <= s1_row;
    s2_meta.fix    <= '0;
    s2_meta.face   <= s1_face;
    s2_meta.tex_u  <= s1_tu;
    s2_dist        <= s1_dist;
    s2_cos         <= cos_val;

    s3_meta <= s2_meta;
    s3_prod <= {17'd0, s2_dist} * {24'd0, s2_cos};
  end

  assign fix_raw = s3_prod[39:24];

  always_comb begin
    push_data = s3_meta;
    push_data.fix = (fix_raw == '0) ? FIX_BITS'(1) : fix_raw;
  end

  assign push = s3_valid;

endmodule

>>> src/rwcs_fifo.sv
// Request queue between the front and back ends.
module rwcs_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  rwcs_pkg::req_t                      push_data,
  input  logic                                pop,
  output rwcs_pkg::req_t                      head,
  output logic [rwcs_pkg::FIFO_CNT_BITS-1:0]  count
);
  import rwcs_pkg::*;

  req_t                     mem [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
    end
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head = mem[rd_ptr];

endmodule

>>> src/rwcs_back.sv
// Back end: wall height divider, row classification, texel row divider.
module rwcs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  rwcs_pkg::req_t       in_req,
  input  logic [23:0]          height_scale,
  input  logic [11:0]          screen_height,
  input  logic [31:0]          ceiling_color,
  input  logic [31:0]          floor_color,
  output logic                 done,
  output logic [11:0]          out_column,
  output logic [11:0]          out_row,
  output logic [1:0]           region,
  output logic [1:0]           face,
  output logic [5:0]           tex_u,
  output logic [5:0]           tex_v,
  output logic [31:0]          pixel_color
);
  import rwcs_pkg::*;

  logic                  dv_valid [0:SCALE_BITS];
  req_t                  dv_req   [0:SCALE_BITS];
  logic [FIX_BITS:0]     dv_rem   [0:SCALE_BITS];
  logic [SCALE_BITS-1:0] dv_quo   [0:SCALE_BITS];

  logic                  tv_valid [0:TILE_BITS];
  logic [11:0]           tv_column[0:TILE_BITS];
  logic [11:0]           tv_row   [0:TILE_BITS];
  logic [1:0]            tv_region[0:TILE_BITS];
  logic [1:0]            tv_face  [0:TILE_BITS];
  logic [TILE_BITS-1:0]  tv_u     [0:TILE_BITS];
  logic [31:0]           tv_color [0:TILE_BITS];
  logic [SCALE_BITS-1:0] tv_h     [0:TILE_BITS];
  logic [SCALE_BITS:0]   tv_rem   [0:TILE_BITS];
  logic [TILE_BITS-1:0]  tv_quo   [0:TILE_BITS];

  logic [SCALE_BITS-1:0] h;
  logic [10:0]           hh2;
  logic [SCALE_BITS-2:0] h2;
  logic [SCALE_BITS-1:0] start_row, end_row, sum;
  logic [SCALE_BITS:0]   dd;
  logic [1:0]            cls_region;
  logic [31:0]           cls_color;

  always_comb begin
    h   = dv_quo[SCALE_BITS];
    hh2 = screen_height[11:1];
    h2  = h[SCALE_BITS-1:1];
    start_row = ({1'b0, h2} >= SCALE_BITS'(hh2)) ? '0 : (SCALE_BITS'(hh2) - {1'b0, h2});
    sum     = SCALE_BITS'(hh2) + {1'b0, h2};
    end_row = (sum > SCALE_BITS'(screen_height)) ? SCALE_BITS'(screen_height) : sum;
    dd = (SCALE_BITS+1)'(dv_req[SCALE_BITS].row) + (SCALE_BITS+1)'(h2)
         - (SCALE_BITS+1)'(hh2);
    if (SCALE_BITS'(dv_req[SCALE_BITS].row) < start_row) begin
      cls_region = REGION_CEILING;
      cls_color  = ceiling_color;
    end else if (SCALE_BITS'(dv_req[SCALE_BITS].row) < end_row) begin
      cls_region = REGION_WALL;
      cls_color  = '0;
    end else begin
      cls_region = REGION_FLOOR;
      cls_color  = floor_color;
    end
  end

  always_ff @(posedge clk) begin
    logic [FIX_BITS+1:0]   r_sh;
    logic [SCALE_BITS+1:0] t_sh;
    if (rst) begin
      for (int i = 0; i <= SCALE_BITS; i++) dv_valid[i] <= 1'b0;
      for (int i = 0; i <= TILE_BITS; i++) tv_valid[i] <= 1'b0;
    end else begin
      dv_valid[0] <= in_valid;
      for (int i = 0; i < SCALE_BITS; i++) dv_valid[i+1] <= dv_valid[i];
      tv_valid[0] <= dv_valid[SCALE_BITS];
      for (int i = 0; i < TILE_BITS; i++) tv_valid[i+1] <= tv_valid[i];
    end

    dv_req[0] <= in_req;
    dv_rem[0] <= '0;
    dv_quo[0] <= '0;
    for (int i = 0; i < SCALE_BITS; i++) begin
      r_sh = {dv_rem[i], height_scale[SCALE_BITS-1-i]};
      dv_req[i+1] <= dv_req[i];
      if (r_sh >= (FIX_BITS+2)'(dv_req[i].fix)) begin
        dv_rem[i+1] <= (FIX_BITS+1)'(r_sh - (FIX_BITS+2)'(dv_req[i].fix));
        dv_quo[i+1] <= {dv_quo[i][SCALE_BITS-2:0], 1'b1};
      end else begin
        dv_rem[i+1] <= r_sh[FIX_BITS:0];
        dv_quo[i+1] <= {dv_quo[i][SCALE_BITS-2:0], 1'b0};
      end
    end

    tv_column[0] <= dv_req[SCALE_BITS].column;
    tv_row[0]    <= dv_req[SCALE_BITS].row;
    tv_region[0] <= cls_region;
    tv_face[0]   <= (cls_region == REGION_WALL) ? dv_req[SCALE_BITS].face : 2'd0;
    tv_u[0]      <= (cls_region == REGION_WALL) ? dv_req[SCALE_BITS].tex_u : '0;
    tv_color[0]  <= cls_color;
    tv_h[0]      <= h;
    tv_rem[0]    <= dd;
    tv_quo[0]    <= '0;
    for (int i = 0; i < TILE_BITS; i++) begin
      t_sh = {tv_rem[i], 1'b0};
      tv_column[i+1] <= tv_column[i];
      tv_row[i+1]    <= tv_row[i];
      tv_region[i+1] <= tv_region[i];
      tv_face[i+1]   <= tv_face[i];
      tv_u[i+1]      <= tv_u[i];
      tv_color[i+1]  <= tv_color[i];
      tv_h[i+1]      <= tv_h[i];
      if (t_sh >= (SCALE_BITS+2)'(tv_h[i])) begin
        tv_rem[i+1] <= (SCALE_BITS+1)'(t_sh - (SCALE_BITS+2)'(tv_h[i]));
        tv_quo[i+1] <= {tv_quo[i][TILE_BITS-2:0], 1'b1};
      end else begin
        tv_rem[i+1] <= t_sh[SCALE_BITS:0];
        tv_quo[i+1] <= {tv_quo[i][TILE_BITS-2:0], 1'b0};
      end
    end
  end

  assign done        = tv_valid[TILE_BITS];
  assign out_column  = tv_column[TILE_BITS];
  assign out_row     = tv_row[TILE_BITS];
  assign region      = tv_region[TILE_BITS];
  assign face        = tv_face[TILE_BITS];
  assign tex_u       = tv_u[TILE_BITS];
  assign tex_v       = (tv_region[TILE_BITS] == REGION_WALL) ? tv_quo[TILE_BITS] : '0;
  assign pixel_color = tv_color[TILE_BITS];

endmodule
